/* design/dcbt_pkg.sv */
`default_nettype none
package dcbt_pkg;
  localparam int TICKS_DEF     = 16;
  localparam int CHUNKS_DEF    = 16;
  localparam int TRANSFERS_DEF = 8;
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_MEASURE = 3'd1;
  localparam logic [2:0] ACT_REBAL   = 3'd2;
  localparam logic [2:0] ACT_OPEN    = 3'd3;
  localparam logic [2:0] ACT_CLOSE   = 3'd4;
  localparam logic [2:0] ACT_RELEASE = 3'd5;
  localparam logic CMD_RESUME  = 1'b0;
  localparam logic CMD_SUSPEND = 1'b1;
  localparam logic [16:0] ONE_Q16   = 17'd65536;
  localparam logic [16:0] RATIO_MIN = 17'd49152;
  localparam logic [16:0] RATIO_MAX = 17'd81920;
  typedef struct packed {
    logic start;
    logic [47:0] num;
    logic [35:0] den;
  } div_req_t;
  typedef struct packed {
    logic busy;
    logic done;
    logic [47:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

/* design/dcbt_div.sv */
`default_nettype none
module dcbt_div (
  input  wire              clk,
  input  wire              rst_n,
  input  dcbt_pkg::div_req_t req,
  output dcbt_pkg::div_rsp_t rsp
);
  logic [47:0] q_r, q_nxt;
  logic [35:0] rem_r, rem_nxt, den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [36:0] sh;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    sh = {rem_r, q_r[47]};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; cnt_nxt = 6'd0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = 36'(sh - {1'b0, den_r});
        q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = sh[35:0];
        q_nxt = {q_r[46:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd47) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
endmodule
`default_nettype wire

/* design/duty_cycle_bandwidth_throttle.sv */
// Tick: emits up to CHUNKS items, one per cycle, stalls on out_ready.
// Rebalance: accept, sum of the TRANSFERS rates, divider start, the bit-serial divider,
//   then scaling of the CHUNKS caps and adjusts through two multipliers.
// Measure, open, close, release complete on accept. One item at a time; in_ready low while busy.
// Reset (rst_n low, synchronous) clears counter, active bits, rates, prev counts and
//   sets max_bandwidth to all ones. Cap and adjust stores are not reset.
`default_nettype none
module duty_cycle_bandwidth_throttle #(
  parameter int TICKS     = dcbt_pkg::TICKS_DEF,
  parameter int CHUNKS    = dcbt_pkg::CHUNKS_DEF,
  parameter int TRANSFERS = dcbt_pkg::TRANSFERS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_action,
  input  wire  [2:0]  in_transfer_slot,
  input  wire  [3:0]  in_chunk_slot,
  input  wire  [31:0] in_transmit_count,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        out_command,
  output logic [3:0]  out_target_chunk,
  output logic [16:0] out_adjust_value,
  output logic        out_last,
  input  wire         cfg_we,
  input  wire  [31:0] cfg_data
);
  localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int TW = (TRANSFERS > 1) ? $clog2(TRANSFERS) : 1;
  localparam logic [7:0] TMAX = 8'(TICKS - 1);

  localparam logic [2:0] S_IDLE = 3'd0, S_TICK = 3'd1, S_SUM = 3'd2, S_DIV = 3'd3,
                         S_SCALE = 3'd4, S_EMIT = 3'd5, S_FLUSH = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [31:0] maxbw_r;
  logic [7:0]  tick_r, tick_nxt;
  logic [CHUNKS-1:0] act_r, act_nxt;
  logic [7:0]  cap_m [CHUNKS];
  logic [16:0] adj_m [CHUNKS];
  logic [31:0] rate_r [TRANSFERS];
  logic [31:0] prev_r [TRANSFERS];
  logic [CW:0] ci_r, ci_nxt;
  logic [TW:0] ti_r, ti_nxt;
  logic [35:0] sum_r, sum_nxt;
  logic [16:0] ratio_r;
  logic        pend_r, pend_nxt;
  logic        ob_cmd_r; logic [3:0] ob_tgt_r; logic [16:0] ob_adj_r;
  logic        hit;
  logic [CW-1:0] ci;
  logic [16:0] cur_adj;
  logic [7:0]  cur_cap;
  logic [33:0] pa, pc;
  logic [16:0] new_adj;
  logic [7:0]  new_cap;
  logic        mem_we;
  logic        out_load;
  logic        ochan_free;
  dcbt_pkg::div_req_t dreq;
  dcbt_pkg::div_rsp_t drsp;
  logic [47:0] q;

  dcbt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign ci = ci_r[CW-1:0];
  assign cur_adj = adj_m[ci];
  assign cur_cap = cap_m[ci];
  assign pa = {17'd0, cur_adj} * {17'd0, ratio_r};
  assign pc = {26'd0, cur_cap} * {17'd0, ratio_r};
  assign new_adj = (pa[33:16] > {1'b0, dcbt_pkg::ONE_Q16}) ? dcbt_pkg::ONE_Q16 : pa[32:16];
  assign new_cap = (pc[33:16] > {10'd0, TMAX}) ? TMAX :
                   (pc[33:16] == 18'd0) ? 8'd1 : pc[23:16];
  assign hit = act_r[ci] && ((tick_r == 8'd0) || (tick_r == cur_cap));
  assign ochan_free = !out_valid || out_ready;
  assign in_ready = (st_r == S_IDLE);
  assign q = drsp.quo;

  always_comb begin
    st_nxt = st_r; tick_nxt = tick_r; act_nxt = act_r; ci_nxt = ci_r; ti_nxt = ti_r;
    sum_nxt = sum_r; pend_nxt = pend_r; mem_we = 1'b0; out_load = 1'b0;
    dreq.start = 1'b0; dreq.num = {maxbw_r, 16'd0}; dreq.den = sum_r;
    case (st_r)
      S_IDLE: if (in_valid) begin
        ci_nxt = '0; ti_nxt = '0; sum_nxt = 36'd1;
        case (in_action)
          dcbt_pkg::ACT_TICK: begin
            tick_nxt = ({24'd0, tick_r} + 32'd1 >= 32'(TICKS)) ? 8'd0 : tick_r + 8'd1;
            pend_nxt = 1'b0; st_nxt = S_TICK;
          end
          dcbt_pkg::ACT_REBAL: st_nxt = S_SUM;
          dcbt_pkg::ACT_OPEN: if ({28'd0, in_chunk_slot} < 32'(CHUNKS)) begin
            act_nxt[in_chunk_slot[CW-1:0]] = 1'b1;
          end
          dcbt_pkg::ACT_CLOSE: if ({28'd0, in_chunk_slot} < 32'(CHUNKS)) begin
            act_nxt[in_chunk_slot[CW-1:0]] = 1'b0;
          end
          default: ;
        endcase
      end
      S_TICK: if (ochan_free || !pend_r || !hit) begin
        if (hit) begin
          if (pend_r) out_load = 1'b1;
          pend_nxt = 1'b1;
        end
        if ({{(31-CW){1'b0}}, ci_r} == 32'(CHUNKS - 1)) st_nxt = S_FLUSH;
        else ci_nxt = ci_r + 1'b1;
      end
      S_FLUSH: if (!pend_r) st_nxt = S_IDLE;
        else if (ochan_free) begin
          out_load = 1'b1; pend_nxt = 1'b0; st_nxt = S_IDLE;
        end
      S_SUM: begin
        sum_nxt = sum_r + {4'd0, rate_r[ti_r[TW-1:0]]};
        if ({{(31-TW){1'b0}}, ti_r} == 32'(TRANSFERS - 1)) st_nxt = S_EMIT;
        else ti_nxt = ti_r + 1'b1;
      end
      S_EMIT: begin
        dreq.start = 1'b1; st_nxt = S_DIV;
      end
      S_DIV: if (drsp.done) st_nxt = S_SCALE;
      S_SCALE: begin
        mem_we = act_r[ci];
        if ({{(31-CW){1'b0}}, ci_r} == 32'(CHUNKS - 1)) st_nxt = S_IDLE;
        else ci_nxt = ci_r + 1'b1;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; tick_r <= '0; act_r <= '0; maxbw_r <= 32'hFFFF_FFFF;
      out_valid <= 1'b0; pend_r <= 1'b0; ci_r <= '0; ti_r <= '0;
      for (int i = 0; i < TRANSFERS; i++) begin
        rate_r[i] <= '0; prev_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt; tick_r <= tick_nxt; act_r <= act_nxt; pend_r <= pend_nxt;
      ci_r <= ci_nxt; ti_r <= ti_nxt;
      if (cfg_we) maxbw_r <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (st_r == S_IDLE && in_valid &&
          {29'd0, in_transfer_slot} < 32'(TRANSFERS)) begin
        if (in_action == dcbt_pkg::ACT_MEASURE) begin
          if (prev_r[in_transfer_slot[TW-1:0]] != 32'd0)
            rate_r[in_transfer_slot[TW-1:0]] <=
              (in_transmit_count >= prev_r[in_transfer_slot[TW-1:0]]) ?
              in_transmit_count - prev_r[in_transfer_slot[TW-1:0]] : 32'd0;
          prev_r[in_transfer_slot[TW-1:0]] <= in_transmit_count;
        end else if (in_action == dcbt_pkg::ACT_RELEASE) begin
          rate_r[in_transfer_slot[TW-1:0]] <= '0;
          prev_r[in_transfer_slot[TW-1:0]] <= '0;
        end
      end
    end
    sum_r <= sum_nxt;
    if (st_r == S_DIV && drsp.done)
      ratio_r <= (q > {31'd0, dcbt_pkg::RATIO_MAX}) ? dcbt_pkg::RATIO_MAX :
                 (q < {31'd0, dcbt_pkg::RATIO_MIN}) ? dcbt_pkg::RATIO_MIN : q[16:0];
    if (mem_we) begin
      adj_m[ci] <= new_adj; cap_m[ci] <= new_cap;
    end else if (st_r == S_IDLE && in_valid && in_action == dcbt_pkg::ACT_OPEN &&
                 {28'd0, in_chunk_slot} < 32'(CHUNKS)) begin
      adj_m[in_chunk_slot[CW-1:0]] <= dcbt_pkg::ONE_Q16;
      cap_m[in_chunk_slot[CW-1:0]] <= TMAX;
    end
    if (st_r == S_TICK && hit && (ochan_free || !pend_r)) begin
      ob_cmd_r <= (tick_r == 8'd0) ? dcbt_pkg::CMD_RESUME : dcbt_pkg::CMD_SUSPEND;
      ob_tgt_r <= 4'(ci_r);
      ob_adj_r <= (tick_r == 8'd0) ? 17'd0 : cur_adj;
    end
    if (out_load) begin
      out_command <= ob_cmd_r; out_target_chunk <= ob_tgt_r;
      out_adjust_value <= ob_adj_r; out_last <= (st_r == S_FLUSH);
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !drsp.busy) else $error("divider busy while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_target_chunk)) else $error("output moved");
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && st_r == S_FLUSH) |=> out_last) else $error("last missing");
  a_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCALE) |-> (ratio_r >= dcbt_pkg::RATIO_MIN && ratio_r <= dcbt_pkg::RATIO_MAX))
    else $error("ratio out of range");
`endif
endmodule
`default_nettype wire

/* test/duty_cycle_bandwidth_throttle_tb.sv */
`default_nettype none
module duty_cycle_bandwidth_throttle_tb;

  localparam int NCH = dcbt_pkg::CHUNKS_DEF;
  localparam int NTR = dcbt_pkg::TRANSFERS_DEF;
  localparam int NTK = dcbt_pkg::TICKS_DEF;
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  chunk;
    logic [16:0] adj;
    logic        last;
  } chunk_cmd_t;

  typedef struct {
    logic [2:0]  act;
    logic [2:0]  ts;
    logic [3:0]  cs;
    logic [31:0] cnt;
    int          reps;
    int          n_cmds;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_action;
  logic [2:0]  in_transfer_slot;
  logic [3:0]  in_chunk_slot;
  logic [31:0] in_transmit_count;
  logic        out_valid;
  logic        out_ready;
  logic        out_command;
  logic [3:0]  out_target_chunk;
  logic [16:0] out_adjust_value;
  logic        out_last;
  logic        cfg_we;
  logic [31:0] cfg_data;

  duty_cycle_bandwidth_throttle u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_transfer_slot (in_transfer_slot),
    .in_chunk_slot    (in_chunk_slot),
    .in_transmit_count(in_transmit_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command      (out_command),
    .out_target_chunk (out_target_chunk),
    .out_adjust_value (out_adjust_value),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data)
  );

  // throttle state mirror
  logic [31:0] bw_target;
  logic [7:0]  tick_pos;
  logic        ch_open [NCH];
  logic [7:0]  ch_cap [NCH];
  logic [16:0] ch_adj [NCH];
  logic [31:0] xfer_rate [NTR];
  logic [31:0] xfer_prev [NTR];

  chunk_cmd_t cmd_q[$];
  int  mismatches;
  int  row_cmds;
  bit  idle_on;
  bit  hold_req;
  int  quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic predict_item(input logic [2:0] act, input logic [2:0] ts,
                              input logic [3:0] cs, input logic [31:0] cnt,
                              output int n);
    logic [35:0] total;
    logic [47:0] ratio;
    logic [63:0] prod;
    chunk_cmd_t  c;
    n = 0;
    case (act)
      dcbt_pkg::ACT_TICK: begin
        tick_pos = (tick_pos + 8'd1 >= NTK) ? 8'd0 : tick_pos + 8'd1;
        for (int i = 0; i < NCH; i++) begin
          if (ch_open[i] && (tick_pos == 0 || tick_pos == ch_cap[i])) begin
            c.cmd   = (tick_pos == 0) ? dcbt_pkg::CMD_RESUME : dcbt_pkg::CMD_SUSPEND;
            c.chunk = i[3:0];
            c.adj   = (tick_pos == 0) ? 17'd0 : ch_adj[i];
            c.last  = 1'b0;
            cmd_q.push_back(c);
            n++;
          end
        end
        if (n > 0) cmd_q[$].last = 1'b1;
      end
      dcbt_pkg::ACT_MEASURE: begin
        if (xfer_prev[ts] != 0)
          xfer_rate[ts] = (cnt >= xfer_prev[ts]) ? cnt - xfer_prev[ts] : 32'd0;
        xfer_prev[ts] = cnt;
      end
      dcbt_pkg::ACT_REBAL: begin
        total = 36'd1;
        for (int i = 0; i < NTR; i++) total += xfer_rate[i];
        ratio = {bw_target, 16'd0} / total;
        if (ratio > dcbt_pkg::RATIO_MAX) ratio = dcbt_pkg::RATIO_MAX;
        if (ratio < dcbt_pkg::RATIO_MIN) ratio = dcbt_pkg::RATIO_MIN;
        for (int i = 0; i < NCH; i++) begin
          if (ch_open[i]) begin
            prod = (64'(ch_adj[i]) * ratio) >> 16;
            ch_adj[i] = (prod > dcbt_pkg::ONE_Q16) ? dcbt_pkg::ONE_Q16 : prod[16:0];
            prod = (64'(ch_cap[i]) * ratio) >> 16;
            if (prod > NTK - 1) ch_cap[i] = 8'(NTK - 1);
            else if (prod == 0) ch_cap[i] = 8'd1;
            else ch_cap[i] = prod[7:0];
          end
        end
      end
      dcbt_pkg::ACT_OPEN: begin
        ch_open[cs] = 1'b1;
        ch_cap[cs]  = 8'(NTK - 1);
        ch_adj[cs]  = dcbt_pkg::ONE_Q16;
      end
      dcbt_pkg::ACT_CLOSE: ch_open[cs] = 1'b0;
      dcbt_pkg::ACT_RELEASE: begin
        xfer_rate[ts] = 32'd0;
        xfer_prev[ts] = 32'd0;
      end
      default: ;
    endcase
  endtask

  // accept and output sides: predict and check
  always @(posedge clk) begin
    int n;
    chunk_cmd_t exp_c;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && in_ready) begin
        moved = 1'b1;
        predict_item(in_action, in_transfer_slot, in_chunk_slot, in_transmit_count, n);
        if (row_cmds >= 0 && n != row_cmds) begin
          mismatches++;
          if (mismatches <= 10)
            $display("item action %0d: expected %0d commands, predicted %0d",
                     in_action, row_cmds, n);
        end
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (cmd_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected command: cmd %0d chunk %0d adj %0d last %0d",
                     out_command, out_target_chunk, out_adjust_value, out_last);
        end else begin
          exp_c = cmd_q.pop_front();
          if (exp_c.cmd !== out_command || exp_c.chunk !== out_target_chunk ||
              exp_c.adj !== out_adjust_value || exp_c.last !== out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("command mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       exp_c.cmd, exp_c.chunk, exp_c.adj, exp_c.last, out_command,
                       out_target_chunk, out_adjust_value, out_last);
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("duty_cycle_bandwidth_throttle_tb failed");
        $finish;
      end
    end
  end

  // result side
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      if (idle_on && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_item(input logic [2:0] act, input logic [2:0] ts,
                           input logic [3:0] cs, input logic [31:0] cnt, input int n_cmds);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    row_cmds          = n_cmds;
    in_valid          <= 1'b1;
    in_action         <= act;
    in_transfer_slot  <= ts;
    in_chunk_slot     <= cs;
    in_transmit_count <= cnt;
    @(posedge clk);
    while (!(in_valid && in_ready)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_bandwidth(input logic [31:0] v);
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    bw_target = v;
  endtask

  task automatic random_item();
    logic [2:0]  act;
    logic [2:0]  ts;
    logic [3:0]  cs;
    logic [31:0] cnt;
    int r;
    r   = $urandom_range(0, 99);
    ts  = 3'($urandom_range(0, NTR - 1));
    cs  = 4'($urandom_range(0, NCH - 1));
    cnt = $urandom;
    if (r < 45) act = dcbt_pkg::ACT_TICK;
    else if (r < 62) begin
      act = dcbt_pkg::ACT_MEASURE;
      case ($urandom_range(0, 5))
        0: cnt = 32'd0;
        1: ;
        2: cnt = xfer_prev[ts] - $urandom_range(0, 500);
        default: cnt = xfer_prev[ts] + $urandom_range(0, 20000);
      endcase
    end
    else if (r < 72) act = dcbt_pkg::ACT_REBAL;
    else if (r < 84) act = dcbt_pkg::ACT_OPEN;
    else if (r < 92) act = dcbt_pkg::ACT_CLOSE;
    else if (r < 97) act = dcbt_pkg::ACT_RELEASE;
    else act = (r[0]) ? ACT_SPARE7 : ACT_SPARE6;
    send_item(act, ts, cs, cnt, -1);
  endtask

  stim_row_t rows [20];
  logic [31:0] bw_plan [5];

  initial begin
    rows[0]  = '{dcbt_pkg::ACT_TICK,    3'd0, 4'd0,  32'd0,          1,  0};
    rows[1]  = '{dcbt_pkg::ACT_OPEN,    3'd0, 4'd0,  32'd0,          1,  0};
    rows[2]  = '{dcbt_pkg::ACT_OPEN,    3'd7, 4'd15, 32'hFFFFFFFF,   1,  0};
    rows[3]  = '{dcbt_pkg::ACT_OPEN,    3'd0, 4'd3,  32'd0,          1,  0};
    rows[4]  = '{dcbt_pkg::ACT_CLOSE,   3'd0, 4'd3,  32'd0,          1,  0};
    rows[5]  = '{dcbt_pkg::ACT_MEASURE, 3'd0, 4'd0,  32'd100,        1,  0};
    rows[6]  = '{dcbt_pkg::ACT_MEASURE, 3'd0, 4'd0,  32'hFFFFFFFF,   1,  0};
    rows[7]  = '{dcbt_pkg::ACT_MEASURE, 3'd7, 4'd0,  32'd50,         1,  0};
    rows[8]  = '{dcbt_pkg::ACT_MEASURE, 3'd7, 4'd0,  32'd10,         1,  0};
    rows[9]  = '{ACT_SPARE6,            3'd0, 4'd0,  32'd0,          1,  0};
    rows[10] = '{ACT_SPARE7,            3'd7, 4'd15, 32'hFFFFFFFF,   1,  0};
    rows[11] = '{dcbt_pkg::ACT_TICK,    3'd0, 4'd0,  32'd0,          13, 0};
    rows[12] = '{dcbt_pkg::ACT_TICK,    3'd7, 4'd15, 32'hFFFFFFFF,   1,  2};
    rows[13] = '{dcbt_pkg::ACT_TICK,    3'd0, 4'd0,  32'd0,          1,  2};
    rows[14] = '{dcbt_pkg::ACT_REBAL,   3'd0, 4'd0,  32'd0,          1,  0};
    rows[15] = '{dcbt_pkg::ACT_RELEASE, 3'd0, 4'd0,  32'd0,          1,  0};
    rows[16] = '{dcbt_pkg::ACT_REBAL,   3'd0, 4'd0,  32'd0,          1,  0};
    rows[17] = '{dcbt_pkg::ACT_OPEN,    3'd0, 4'd8,  32'd0,          1,  0};
    rows[18] = '{dcbt_pkg::ACT_TICK,    3'd0, 4'd0,  32'd0,          15, -1};
    rows[19] = '{dcbt_pkg::ACT_MEASURE, 3'd3, 4'd0,  32'd0,          1,  0};
    bw_plan[0] = 32'd0;
    bw_plan[1] = $urandom;
    bw_plan[2] = $urandom_range(1000, 60000);
    bw_plan[3] = 32'hFFFFFFFF;
    bw_plan[4] = $urandom_range(0, 30000);

    bw_target = 32'hFFFFFFFF;
    tick_pos  = 8'd0;
    for (int i = 0; i < NCH; i++) begin
      ch_open[i] = 1'b0;
      ch_cap[i]  = 8'd0;
      ch_adj[i]  = 17'd0;
    end
    for (int i = 0; i < NTR; i++) begin
      xfer_rate[i] = 32'd0;
      xfer_prev[i] = 32'd0;
    end
    mismatches = 0;
    row_cmds = -1;
    idle_on = 1'b1;
    hold_req = 1'b0;
    quiet_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = dcbt_pkg::ACT_TICK;
    in_transfer_slot = 3'd0;
    in_chunk_slot = 4'd0;
    in_transmit_count = 32'd0;
    cfg_we = 1'b0;
    cfg_data = 32'd0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i])
      repeat (rows[i].reps)
        send_item(rows[i].act, rows[i].ts, rows[i].cs, rows[i].cnt, rows[i].n_cmds);

    for (int p = 0; p < 5; p++) begin
      set_bandwidth(bw_plan[p]);
      idle_on = (p != 4);
      for (int k = 0; k < 85; k++) begin
        if (p == 1 && k == 10) hold_req = 1'b1;
        random_item();
      end
    end

    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("duty_cycle_bandwidth_throttle_tb passed");
    else
      $display("duty_cycle_bandwidth_throttle_tb failed");
    $finish;
  end
endmodule
`default_nettype wire
